// File: design/tmfc_pkg.sv
// ----------------------------------------------------------------------------
// tmfc_pkg - shared types and codes for the timestamp matched frame cache
// Holds the controller states, lookup status codes, register index,
// and the control bundle sent to each storage cell.
// ----------------------------------------------------------------------------
package tmfc_pkg;

  // Fixed field widths
  localparam int TS_BITS    = 64;
  localparam int LIMIT_BITS = 5;
  localparam int APB_BITS   = 32;
  localparam int ADDR_BITS  = 3;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  // Input action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Register index (paddr[2])
  localparam logic REG_ENTRY_LIMIT = 1'b0;

  // Lookup status codes
  localparam logic [1:0] STAT_SENT     = 2'd0;
  localparam logic [1:0] STAT_CONSUMED = 2'd1;
  localparam logic [1:0] STAT_DROPPED  = 2'd2;
  localparam logic [1:0] STAT_PENDING  = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DROP,
    ST_DONE
  } state_t;

  // Per-cell control: rotate the ring, or load a new entry
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: design/tmfc_cell.sv
// ----------------------------------------------------------------------------
// tmfc_cell - one entry of the rotating entry ring
// Holds timestamp, sent flag and handle. Takes its neighbor's entry on a
// shift, or a fresh entry (sent cleared) on a load; load wins.
// ----------------------------------------------------------------------------
module tmfc_cell #(
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  tmfc_pkg::cell_ctl_t           ctl,
  input  logic [tmfc_pkg::TS_BITS-1:0]  nbr_time,
  input  logic                          nbr_sent,
  input  logic [HANDLE_BITS-1:0]        nbr_handle,
  input  logic [tmfc_pkg::TS_BITS-1:0]  ld_time,
  input  logic [HANDLE_BITS-1:0]        ld_handle,
  output logic [tmfc_pkg::TS_BITS-1:0]  time_q,
  output logic                          sent_q,
  output logic [HANDLE_BITS-1:0]        handle_q
);

  // Entry storage, payload only
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      time_q   <= ld_time;
      sent_q   <= 1'b0;
      handle_q <= ld_handle;
    end else if (ctl.shift) begin
      time_q   <= nbr_time;
      sent_q   <= nbr_sent;
      handle_q <= nbr_handle;
    end
  end

endmodule

// File: design/timestamp_matched_frame_cache.sv
// ----------------------------------------------------------------------------
// timestamp_matched_frame_cache - bounded FIFO of frames matched by timestamp
// Entries sit in a ring of cells, oldest in cell 0. Inserts load one cell;
// lookups rotate the ring once around, examining cell 0 each cycle.
//
//   Channel  Dir  Payload                                  Transaction
//   s_*      in   tuser: action; tdata: timestamp, handle  insert / lookup
//   m_*      out  tuser: status; tdata: handle, held cnt   one per lookup
//   apb      in   entry_limit at address 0                 register write
//
// Inserts and zero-timestamp lookups leave the controller in ST_IDLE with
// s_tready high; a zero-timestamp lookup gives no result. A lookup passes
//   through ST_SCAN, ST_DROP and ST_DONE, with s_tready low throughout.
// The result waits in an output register; a stalled m_tready holds the
// controller in its result cycle. Synchronous reset empties the cache.
// ----------------------------------------------------------------------------
module timestamp_matched_frame_cache #(
  parameter int MAX_ENTRIES = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  // Input stream
  input  logic s_tvalid,
  output logic s_tready,
  // [63:0] timestamp, [64+:HANDLE_BITS] buffer_handle
  input  logic [((tmfc_pkg::TS_BITS+HANDLE_BITS+7)/8)*8-1:0] s_tdata,
  // [0] action
  input  logic [0:0] s_tuser,
  // Result stream
  output logic m_tvalid,
  input  logic m_tready,
  // [HANDLE_BITS-1:0] found_handle, then entries_held
  output logic [((HANDLE_BITS+$clog2(MAX_ENTRIES+1)+7)/8)*8-1:0] m_tdata,
  // [1:0] lookup_status
  output logic [1:0] m_tuser,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tmfc_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [tmfc_pkg::APB_BITS-1:0]     pwdata,
  output logic [tmfc_pkg::APB_BITS-1:0]     prdata,
  output logic                              pready
);

  localparam int TSB    = tmfc_pkg::TS_BITS;
  localparam int HW     = $clog2(MAX_ENTRIES + 1);
  localparam int PW     = $clog2(MAX_ENTRIES);
  localparam int LW     = (HW > tmfc_pkg::LIMIT_BITS) ? HW : tmfc_pkg::LIMIT_BITS;
  localparam int OUT_DW = ((HANDLE_BITS + HW + 7) / 8) * 8;

  // Control and scan state
  tmfc_pkg::state_t              state, state_next;
  logic [tmfc_pkg::LIMIT_BITS-1:0] entry_limit;
  logic [HW-1:0]                 held;
  logic [PW-1:0]                 pos;
  logic [TSB-1:0]                ts;
  logic                          found;
  logic                          was_sent;
  logic                          newer;
  logic                          lead_run;
  logic [HW-1:0]                 drop_cnt;
  logic [HANDLE_BITS-1:0]        hit_handle;

  // Ring contents
  logic [TSB-1:0]          cell_time   [MAX_ENTRIES];
  logic                    cell_sent   [MAX_ENTRIES];
  logic [HANDLE_BITS-1:0]  cell_handle [MAX_ENTRIES];
  tmfc_pkg::cell_ctl_t     cell_ctl    [MAX_ENTRIES];

  logic                    in_acc;
  logic                    is_insert;
  logic [TSB-1:0]          in_ts;
  logic [HANDLE_BITS-1:0]  in_handle;
  logic [LW-1:0]           lim_ext;
  logic [LW-1:0]           eff_lim;
  logic                    evict;
  logic                    do_insert;
  logic [HW-1:0]           wpos;
  logic                    scanning;
  logic                    pos_ok;
  logic                    head_eq;
  logic                    head_lt;
  logic                    first_hit;
  logic                    scan_last;
  logic                    drop_go;
  logic                    rotate;
  logic                    out_free;
  logic                    out_load;
  logic [1:0]              status;
  logic                    cfg_wr;

  // Input fields
  assign in_acc    = s_tvalid && s_tready;
  assign is_insert = (s_tuser[0] == tmfc_pkg::ACT_INSERT);
  assign in_ts     = s_tdata[TSB-1:0];
  assign in_handle = s_tdata[TSB +: HANDLE_BITS];

  // Effective limit: zero acts as one, clamped to capacity
  assign lim_ext = LW'(entry_limit);
  always_comb begin
    if (lim_ext == '0) begin
      eff_lim = LW'(1);
    end else if (lim_ext > LW'(MAX_ENTRIES)) begin
      eff_lim = LW'(MAX_ENTRIES);
    end else begin
      eff_lim = lim_ext;
    end
  end

  // Insert: evict oldest by one rotation, write new entry behind the rest
  assign evict     = (LW'(held) >= eff_lim);
  assign wpos      = evict ? (held - HW'(1)) : held;

  // Head cell compare during the scan
  assign pos_ok    = (HW'(pos) < held);
  assign head_eq   = (cell_time[0] == ts);
  assign head_lt   = (cell_time[0] < ts);
  assign first_hit = scanning && pos_ok && !found && head_eq;
  assign scan_last = (pos == PW'(MAX_ENTRIES - 1));
  assign drop_go   = found && !was_sent && (drop_cnt != '0);

  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    if (found) begin
      status = was_sent ? tmfc_pkg::STAT_CONSUMED : tmfc_pkg::STAT_SENT;
    end else begin
      status = newer ? tmfc_pkg::STAT_DROPPED : tmfc_pkg::STAT_PENDING;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tmfc_pkg::ST_IDLE: begin
        if (in_acc && !is_insert && (in_ts != '0)) state_next = tmfc_pkg::ST_SCAN;
      end
      tmfc_pkg::ST_SCAN: begin
        if (scan_last) state_next = tmfc_pkg::ST_DROP;
      end
      tmfc_pkg::ST_DROP: begin
        if (!drop_go) state_next = tmfc_pkg::ST_DONE;
      end
      tmfc_pkg::ST_DONE: begin
        if (out_free) state_next = tmfc_pkg::ST_IDLE;
      end
      default: state_next = tmfc_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready = 1'b0;
    scanning = 1'b0;
    rotate   = 1'b0;
    out_load = 1'b0;
    case (state)
      tmfc_pkg::ST_IDLE: s_tready = 1'b1;
      tmfc_pkg::ST_SCAN: begin
        scanning = 1'b1;
        rotate   = 1'b1;
      end
      tmfc_pkg::ST_DROP: rotate   = drop_go;
      tmfc_pkg::ST_DONE: out_load = out_free;
      default: s_tready = 1'b0;
    endcase
  end

  assign do_insert = in_acc && is_insert;

  // Cell ring: cell k takes from k+1, last cell closes the ring from cell 0
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    localparam int NB = (k + 1) % MAX_ENTRIES;
    logic nbr_sent;

    assign cell_ctl[k].shift = rotate || (do_insert && evict);
    assign cell_ctl[k].load  = do_insert && (wpos == HW'(k));

    if (k == MAX_ENTRIES - 1) begin : g_wrap
      assign nbr_sent = cell_sent[NB] || first_hit;
    end else begin : g_mid
      assign nbr_sent = cell_sent[NB];
    end

    tmfc_cell #(
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[k]),
      .nbr_time   (cell_time[NB]),
      .nbr_sent   (nbr_sent),
      .nbr_handle (cell_handle[NB]),
      .ld_time    (in_ts),
      .ld_handle  (in_handle),
      .time_q     (cell_time[k]),
      .sent_q     (cell_sent[k]),
      .handle_q   (cell_handle[k])
    );
  end

  // Controller state and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmfc_pkg::ST_IDLE;
      held  <= '0;
    end else begin
      state <= state_next;
      if (do_insert && !evict) begin
        held <= held + HW'(1);
      end else if (state == tmfc_pkg::ST_DROP && drop_go) begin
        held <= held - HW'(1);
      end
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk) begin
    if (state == tmfc_pkg::ST_IDLE) begin
      ts         <= in_ts;
      pos        <= '0;
      found      <= 1'b0;
      was_sent   <= 1'b0;
      newer      <= 1'b0;
      lead_run   <= 1'b1;
      drop_cnt   <= '0;
      hit_handle <= '0;
    end else if (scanning) begin
      pos <= pos + PW'(1);
      if (pos_ok) begin
        if (first_hit) begin
          found      <= 1'b1;
          was_sent   <= cell_sent[0];
          hit_handle <= cell_handle[0];
        end
        if (!head_eq && !head_lt) newer <= 1'b1;
        if (lead_run && head_lt) begin
          drop_cnt <= drop_cnt + HW'(1);
        end else begin
          lead_run <= 1'b0;
        end
      end
    end else if (state == tmfc_pkg::ST_DROP && drop_go) begin
      drop_cnt <= drop_cnt - HW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= status;
      m_tdata <= OUT_DW'({held, (status == tmfc_pkg::STAT_SENT) ? hit_handle
                                                                 : {HANDLE_BITS{1'b0}}});
    end
  end

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == tmfc_pkg::REG_ENTRY_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= tmfc_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      entry_limit <= pwdata[tmfc_pkg::LIMIT_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == tmfc_pkg::REG_ENTRY_LIMIT) ?
                  tmfc_pkg::APB_BITS'(entry_limit) : '0;

  // Checks
  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    HW'(MAX_ENTRIES) >= held)
    else $error("entry count above capacity");

  a_insert_holds: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (held != '0))
    else $error("cache empty after insert");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == tmfc_pkg::ST_DONE))
    else $error("result raised outside result cycle");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != tmfc_pkg::STAT_SENT)) |-> (m_tdata[HANDLE_BITS-1:0] == '0))
    else $error("handle present on a result that sent nothing");

endmodule

// File: test/tb_timestamp_matched_frame_cache.sv
// ----------------------------------------------------------------------------
// tb_timestamp_matched_frame_cache - self-checking bench for the frame cache
// Drives insert and lookup transactions on the input stream and entry_limit
// writes on the APB port. An in-bench model of the cache ring predicts each
// lookup result. Every result on the output stream is compared field by
// field with the oldest prediction. A directed table comes first, then
// random phases at several limits, most with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_timestamp_matched_frame_cache;

  // Widths and codes from the shared package
  localparam int TS_BITS   = tmfc_pkg::TS_BITS;
  localparam int ADDR_BITS = tmfc_pkg::ADDR_BITS;
  localparam int APB_BITS  = tmfc_pkg::APB_BITS;

  localparam logic       ACT_INSERT      = tmfc_pkg::ACT_INSERT;
  localparam logic       ACT_LOOKUP      = tmfc_pkg::ACT_LOOKUP;
  localparam logic       REG_ENTRY_LIMIT = tmfc_pkg::REG_ENTRY_LIMIT;
  localparam logic [1:0] STAT_SENT       = tmfc_pkg::STAT_SENT;
  localparam logic [1:0] STAT_CONSUMED   = tmfc_pkg::STAT_CONSUMED;
  localparam logic [1:0] STAT_DROPPED    = tmfc_pkg::STAT_DROPPED;
  localparam logic [1:0] STAT_PENDING    = tmfc_pkg::STAT_PENDING;

  localparam int CACHE_DEPTH = 16;
  localparam int HANDLE_W    = 32;
  localparam int SDATA_W     = ((TS_BITS + HANDLE_W + 7) / 8) * 8;
  localparam int MDATA_W     = ((HANDLE_W + $clog2(CACHE_DEPTH + 1) + 7) / 8) * 8;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 219;
  localparam int DRAIN_WAIT  = 60;

  // Register addresses: entry_limit, and an index the block does not decode
  localparam logic [ADDR_BITS-1:0] ADDR_ENTRY_LIMIT = {REG_ENTRY_LIMIT, 2'b00};
  localparam logic [ADDR_BITS-1:0] ADDR_UNMAPPED    = 3'd4;

  localparam logic [63:0] TS_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic                act;
    logic [TS_BITS-1:0]  ts;
    logic [HANDLE_W-1:0] handle;
  } frame_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle;
    logic [4:0]          held;
  } lookup_res_t;

  typedef struct packed {
    frame_req_t  req;
    logic        typed;
    lookup_res_t res;
  } dir_row_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          value;
    logic                 stalls;
  } phase_t;

  // Directed table; typed rows carry the result expected by inspection
  localparam int NUM_DIR = 18;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // lookup on an empty cache stays pending
    '{'{ACT_LOOKUP, 64'd5, 32'd0}, 1'b1, '{STAT_PENDING, 32'd0, 5'd0}},
    // zero timestamp lookup: no result
    '{'{ACT_LOOKUP, 64'd0, 32'hDEAD_BEEF}, 1'b0, '{STAT_SENT, 32'd0, 5'd0}},
    '{'{ACT_INSERT, 64'd10, 32'hAAAA_5555}, 1'b0, '{STAT_SENT, 32'd0, 5'd0}},
    '{'{ACT_INSERT, 64'd20, 32'hFFFF_FFFF}, 1'b0, '{STAT_SENT, 32'd0, 5'd0}},
    '{'{ACT_INSERT, 64'd20, 32'h0000_0000}, 1'b0, '{STAT_SENT, 32'd0, 5'd0}},
    '{'{ACT_INSERT, TS_MAX, 32'h1234_5678}, 1'b0, '{STAT_SENT, 32'd0, 5'd0}},
    // miss with newer entries held: dropped
    '{'{ACT_LOOKUP, 64'd15, 32'd0}, 1'b1, '{STAT_DROPPED, 32'd0, 5'd4}},
    // duplicate stamps: oldest equal entry is sent, older front entry dropped
    '{'{ACT_LOOKUP, 64'd20, 32'd0}, 1'b1, '{STAT_SENT, 32'hFFFF_FFFF, 5'd3}},
    // oldest equal is already sent: consumed, nothing dropped
    '{'{ACT_LOOKUP, 64'd20, 32'd0}, 1'b1, '{STAT_CONSUMED, 32'd0, 5'd3}},
    '{'{ACT_LOOKUP, TS_MAX, 32'd0}, 1'b1, '{STAT_SENT, 32'h1234_5678, 5'd1}},
    '{'{ACT_LOOKUP, TS_MAX, 32'd0}, 1'b1, '{STAT_CONSUMED, 32'd0, 5'd1}},
    '{'{ACT_LOOKUP, 64'h8000_0000_0000_0000, 32'd0}, 1'b1, '{STAT_DROPPED, 32'd0, 5'd1}},
    '{'{ACT_INSERT, 64'd0, 32'h0000_0001}, 1'b0, '{STAT_SENT, 32'd0, 5'd0}},
    '{'{ACT_LOOKUP, 64'd0, 32'd0}, 1'b0, '{STAT_SENT, 32'd0, 5'd0}},
    '{'{ACT_LOOKUP, 64'd1, 32'd0}, 1'b1, '{STAT_DROPPED, 32'd0, 5'd2}},
    '{'{ACT_INSERT, 64'd7, 32'h5A5A_5A5A}, 1'b0, '{STAT_SENT, 32'd0, 5'd0}},
    // match behind a newer front entry: nothing dropped
    '{'{ACT_LOOKUP, 64'd7, 32'd0}, 1'b1, '{STAT_SENT, 32'h5A5A_5A5A, 5'd3}},
    '{'{ACT_LOOKUP, TS_MAX - 64'd1, 32'd0}, 1'b1, '{STAT_DROPPED, 32'd0, 5'd3}}
  };

  // Random phases: register write, then a burst of traffic
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{ADDR_ENTRY_LIMIT, 32'd31, 1'b1},   // above capacity
    '{ADDR_ENTRY_LIMIT, 32'd2,  1'b1},   // lowered below the held count
    '{ADDR_UNMAPPED,    32'd7,  1'b1},   // ignored write
    '{ADDR_ENTRY_LIMIT, 32'd0,  1'b1},   // zero acts as one
    '{ADDR_ENTRY_LIMIT, 32'd1,  1'b0},   // no stalls on either side
    '{ADDR_ENTRY_LIMIT, 32'd16, 1'b1},
    '{ADDR_ENTRY_LIMIT, 32'd17, 1'b1},
    '{ADDR_ENTRY_LIMIT, 32'd5,  1'b1}
  };

  // DUT signals
  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [SDATA_W-1:0]   s_tdata  = '0;   // [63:0] timestamp, [95:64] buffer_handle
  logic [0:0]           s_tuser  = '0;   // [0] action
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [MDATA_W-1:0]   m_tdata;         // [31:0] found_handle, [36:32] entries_held
  logic [1:0]           m_tuser;         // [1:0] lookup_status
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [ADDR_BITS-1:0] paddr    = '0;
  logic [APB_BITS-1:0]  pwdata   = '0;
  logic [APB_BITS-1:0]  prdata;
  logic                 pready;

  // Cache model state
  logic [TS_BITS-1:0]  ring_ts     [CACHE_DEPTH];
  logic                ring_sent   [CACHE_DEPTH];
  logic [HANDLE_W-1:0] ring_handle [CACHE_DEPTH];
  int unsigned         ring_head;
  int unsigned         ring_fill;
  logic [4:0]          limit_reg;

  lookup_res_t         pending_lookups [$];
  logic [TS_BITS-1:0]  recent_ts [$];
  logic [TS_BITS-1:0]  capture_clock;
  bit                  stalls_on;
  int unsigned         error_count;
  lookup_res_t         got_res;
  lookup_res_t         want_res;

  timestamp_matched_frame_cache #(
    .MAX_ENTRIES(CACHE_DEPTH),
    .HANDLE_BITS(HANDLE_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Hard limit on run time
  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned active_limit();
    if (limit_reg == 5'd0) return 1;
    if (limit_reg > CACHE_DEPTH) return CACHE_DEPTH;
    return limit_reg;
  endfunction

  // Apply one transaction to the cache model; a result comes only from a
  // lookup with a nonzero timestamp
  task automatic cache_apply(input frame_req_t req, output bit has_res,
                             output lookup_res_t res);
    int unsigned pos;
    int unsigned slot;
    bit          hit;
    bit          newer;
    has_res = 1'b0;
    res     = '0;
    hit     = 1'b0;
    newer   = 1'b0;
    if (req.act == ACT_INSERT) begin
      // full: evict only the single oldest entry
      if (ring_fill >= active_limit() && ring_fill != 0) begin
        ring_head = (ring_head + 1) % CACHE_DEPTH;
        ring_fill--;
      end
      slot = (ring_head + ring_fill) % CACHE_DEPTH;
      ring_ts[slot]     = req.ts;
      ring_sent[slot]   = 1'b0;
      ring_handle[slot] = req.handle;
      ring_fill++;
    end else if (req.ts != '0) begin
      has_res    = 1'b1;
      res.status = STAT_PENDING;
      for (pos = 0; pos < ring_fill && !hit; pos++) begin
        slot = (ring_head + pos) % CACHE_DEPTH;
        if (ring_ts[slot] == req.ts) begin
          hit = 1'b1;
          if (!ring_sent[slot]) begin
            ring_sent[slot] = 1'b1;
            res.status      = STAT_SENT;
            res.handle      = ring_handle[slot];
          end else begin
            res.status = STAT_CONSUMED;
          end
        end
      end
      if (hit) begin
        // a fresh send retires older frames waiting at the front
        if (res.status == STAT_SENT) begin
          while (ring_fill > 0 && ring_ts[ring_head] < req.ts) begin
            ring_head = (ring_head + 1) % CACHE_DEPTH;
            ring_fill--;
          end
        end
      end else begin
        for (pos = 0; pos < ring_fill; pos++) begin
          if (ring_ts[(ring_head + pos) % CACHE_DEPTH] > req.ts) newer = 1'b1;
        end
        res.status = newer ? STAT_DROPPED : STAT_PENDING;
      end
      res.held = 5'(ring_fill);
    end
  endtask

  // Offer one transaction, with random idle cycles ahead of it when stalls are on
  task automatic send_frame(input frame_req_t req, input bit typed,
                            input lookup_res_t typed_res);
    bit          has_res;
    lookup_res_t res;
    while (stalls_on && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {req.handle, req.ts};
    s_tuser  <= req.act;
    do @(posedge clk); while (!s_tready);
    cache_apply(req, has_res, res);
    if (has_res) pending_lookups.insert(pending_lookups.size(), typed ? typed_res : res);
  endtask

  // Wait for all results, then for the block to go idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_ENTRY_LIMIT) limit_reg = value[4:0];
  endtask

  // Random traffic: mostly inserts on a rising capture clock and lookups of
  // recently stored stamps, with late frames, near misses and noise
  task automatic make_frame(output frame_req_t req);
    int unsigned pick;
    pick       = $urandom_range(0, 99);
    req.handle = $urandom;
    if ($urandom_range(0, 1) == 0) begin
      req.act = ACT_INSERT;
      if (pick < 8 && recent_ts.size() != 0) begin
        req.ts = recent_ts[$];
      end else if (pick < 14) begin
        req.ts = capture_clock - $urandom_range(1, 200);
      end else if (pick < 17) begin
        req.ts = {$urandom, $urandom};
      end else begin
        capture_clock += $urandom_range(1, 40);
        req.ts = capture_clock;
      end
      recent_ts.insert(recent_ts.size(), req.ts);
      if (recent_ts.size() > 20) recent_ts.delete(0);
    end else begin
      req.act = ACT_LOOKUP;
      if (pick < 55 && recent_ts.size() != 0) begin
        req.ts = recent_ts[$urandom_range(0, recent_ts.size() - 1)];
      end else if (pick < 70) begin
        req.ts = capture_clock + $urandom_range(0, 6) - 3;
      end else if (pick < 80) begin
        req.ts = capture_clock + $urandom_range(1, 1000);
      end else if (pick < 85) begin
        req.ts = '0;
      end else begin
        req.ts = {$urandom, $urandom};
      end
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !stalls_on || ($urandom_range(0, 99) >= 25);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = '{m_tuser, m_tdata[HANDLE_W-1:0], m_tdata[HANDLE_W+4:HANDLE_W]};
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected result", 64'(got_res), 64'd0);
      end else begin
        want_res = pending_lookups[0];
        pending_lookups.delete(0);
        if (got_res.status != want_res.status)
          report_mismatch("lookup_status", 64'(got_res.status), 64'(want_res.status));
        if (got_res.handle != want_res.handle)
          report_mismatch("found_handle", 64'(got_res.handle), 64'(want_res.handle));
        if (got_res.held != want_res.held)
          report_mismatch("entries_held", 64'(got_res.held), 64'(want_res.held));
        if (m_tdata[MDATA_W-1:HANDLE_W+5] != '0)
          report_mismatch("tdata padding", 64'(m_tdata[MDATA_W-1:HANDLE_W+5]), 64'd0);
      end
    end
  end

  // Main sequence
  initial begin
    frame_req_t req;
    ring_head   = 0;
    ring_fill   = 0;
    limit_reg   = tmfc_pkg::LIMIT_RESET;
    error_count = 0;
    stalls_on   = 1'b1;
    capture_clock = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_DIR; r++) begin
      send_frame(DIR_ROWS[r].req, DIR_ROWS[r].typed, DIR_ROWS[r].res);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      apb_write(PHASES[p].addr, PHASES[p].value);
      stalls_on = PHASES[p].stalls;
      // fresh capture clock per phase, for one phase close to wrap-around
      if (p == 6) capture_clock = TS_MAX - 64'd3000;
      else capture_clock = {$urandom, $urandom};
      recent_ts.delete();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        make_frame(req);
        send_frame(req, 1'b0, '0);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
